### hw/rtl/usb_hub_port_service_fsm_defines.svh
// Assertion macros for the USB hub port service sequencer.
// Include from within a module that has clk_i and rst_ni.
`ifndef USB_HUB_PORT_SERVICE_FSM_DEFINES_SVH
`define USB_HUB_PORT_SERVICE_FSM_DEFINES_SVH

// Check on every rising edge once reset is released.
`define USBHPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("usbhps: property violated");

// Check on every rising edge, reset included.
`define USBHPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("usbhps: property violated");

`endif

### hw/rtl/usbhps_pkg.sv
// Types and codes for the USB hub port service sequencer.
// No dependencies; imported by usb_hub_port_service_fsm.
package usbhps_pkg;

  typedef enum logic [1:0] {
    CMD_SETUP   = 2'd0,
    CMD_SERVICE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RR_OK    = 2'd0,
    RR_BUSY  = 2'd1,
    RR_FAIL  = 2'd2,
    RR_UNSUP = 2'd3
  } req_result_e;

  typedef enum logic [1:0] {
    TS_PENDING = 2'd0,
    TS_DONE    = 2'd1,
    TS_STALLED = 2'd2,
    TS_RSVD    = 2'd3
  } xfer_state_e;

  typedef enum logic [3:0] {
    ACT_NONE       = 4'd0,
    ACT_GET_DESC   = 4'd1,
    ACT_PORT_POWER = 4'd2,
    ACT_POWER_WAIT = 4'd3,
    ACT_SETUP_DONE = 4'd4,
    ACT_IN_POLL    = 4'd5,
    ACT_CLR_HALT   = 4'd6,
    ACT_GET_STATUS = 4'd7,
    ACT_CLR_SUSP   = 4'd8,
    ACT_CLR_OC     = 4'd9,
    ACT_CLR_CONN   = 4'd10,
    ACT_CLR_RESET  = 4'd11,
    ACT_PORT_RESET = 4'd12,
    ACT_ATTACH     = 4'd13,
    ACT_DETACH     = 4'd14,
    ACT_SETTLE     = 4'd15
  } action_e;

  typedef enum logic [1:0] {
    SU_BUSY   = 2'd0,
    SU_OK     = 2'd1,
    SU_FAILED = 2'd2,
    SU_RSVD   = 2'd3
  } setup_status_e;

  // Port status bits
  localparam int unsigned PS_CONNECT   = 0;
  localparam int unsigned PS_ENABLE    = 1;
  localparam int unsigned PS_RESET     = 4;
  localparam int unsigned PS_POWER     = 8;
  localparam int unsigned PS_LOW_SPEED = 9;

  // Port change bits
  localparam int unsigned PC_CONNECTION  = 0;
  localparam int unsigned PC_SUSPEND     = 2;
  localparam int unsigned PC_OVER_CURRENT = 3;
  localparam int unsigned PC_RESET       = 4;

  localparam logic [8:0] RESET_DELAY_MS  = 9'd150;
  localparam logic [8:0] SETTLE_DELAY_MS = 9'd10;
  localparam logic [7:0] POLL_INTERVAL_RST = 8'd10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] frame_count;
    logic [1:0]  request_result;
    logic [1:0]  transfer_state;
    logic [7:0]  change_bitmap;
    logic [15:0] port_status_word;
    logic [15:0] port_change_word;
    logic [2:0]  desc_port_count;
    logic [7:0]  desc_power_good;
  } req_t;

  typedef struct packed {
    logic [3:0] action;
    logic [2:0] port_number;
    logic       low_speed;
    logic [8:0] delay_ms;
    logic [1:0] setup_status;
  } rsp_t;

endpackage

### hw/rtl/usb_hub_port_service_fsm.sv
// USB hub port service sequencer, top level.
// Depends on usbhps_pkg and usb_hub_port_service_fsm_defines.svh.
//
// Usage: each request on the input channel (in_valid_i/in_stall_o, in_req_i)
// is a setup step, a service step or a frame tick. Every request yields
// exactly one response on the output channel (out_valid_o/out_stall_i,
// out_rsp_o) naming the action the host performs next, the port it addresses,
// the low-speed flag on attach, the wait to apply and the setup status.
// A request is held in the input register; its decision is made from
// that register and the sequencer state and lands in the response register.
// One request per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the response register holds and the input
// register can still take one request; in_stall_o rises only when both are
// full and the output is stalled.
// Reset (rst_ni low, asynchronous) returns the sequencer to descriptor fetch,
// service idle, and poll_interval to 10 frames. cfg_we_i/cfg_wdata_i write
// poll_interval; write it only while no request is in flight.
`include "usb_hub_port_service_fsm_defines.svh"

module usb_hub_port_service_fsm import usbhps_pkg::*; #(
  parameter int unsigned MAX_PORTS = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_rsp_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  // Ports above 7 cannot be addressed by the 3-bit port field.
  localparam int unsigned PortLimit = (MAX_PORTS > 7) ? 7 : MAX_PORTS;
  localparam logic [2:0] PortLimitW = 3'(PortLimit);

  typedef enum logic [1:0] {
    ST_DESC,
    ST_POWER,
    ST_WAIT,
    ST_DONE
  } setup_state_e;

  typedef enum logic [3:0] {
    SV_IDLE,
    SV_SYNC,
    SV_GET,
    SV_POLL,
    SV_LOOP,
    SV_STATUS,
    SV_COC,
    SV_CSUSP,
    SV_CCONN,
    SV_CRESET,
    SV_RESET,
    SV_ATTACH,
    SV_DETACH,
    SV_SETTLE
  } service_state_e;

  setup_state_e   setup_q, setup_d;
  service_state_e service_q, service_d;
  logic [2:0]  active_port_q, active_port_d;
  logic [7:0]  pending_q, pending_d;
  logic [31:0] poll_start_q, poll_start_d;
  logic        data_seen_q, data_seen_d;
  logic [2:0]  port_count_q, port_count_d;
  logic [7:0]  power_good_q, power_good_d;
  logic        held_ls_q, held_ls_d;
  logic [7:0]  poll_interval_q;

  logic in_valid_q;
  req_t in_q;
  logic out_valid_q;
  rsp_t out_q;
  rsp_t rsp_d;

  logic advance;
  logic in_load;
  logic [2:0] lowest;
  logic [2:0] clamped_count;
  logic [31:0] elapsed;

  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & out_valid_q & out_stall_i;
  assign in_load    = in_valid_i & ~in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Lowest changed port in the pending map; port 0 is the hub itself.
  always_comb begin
    lowest = 3'd0;
    for (int p = 7; p >= 1; p--) begin
      if (pending_q[p] && (p <= PortLimit)) begin
        lowest = 3'(p);
      end
    end
  end

  assign clamped_count = (in_q.desc_port_count > PortLimitW) ? PortLimitW
                                                            : in_q.desc_port_count;
  assign elapsed = in_q.frame_count - poll_start_q;

  always_comb begin
    setup_d       = setup_q;
    service_d     = service_q;
    active_port_d = active_port_q;
    pending_d     = pending_q;
    poll_start_d  = poll_start_q;
    data_seen_d   = data_seen_q;
    port_count_d  = port_count_q;
    power_good_d  = power_good_q;
    held_ls_d     = held_ls_q;
    rsp_d         = '0;
    rsp_d.action  = ACT_NONE;

    if (in_q.cmd == CMD_SETUP) begin
      unique case (setup_q)
        ST_DESC: begin
          rsp_d.action = ACT_GET_DESC;
          if (in_q.request_result == RR_OK) begin
            port_count_d  = clamped_count;
            power_good_d  = in_q.desc_power_good;
            active_port_d = 3'd1;
            setup_d       = (clamped_count == 3'd0) ? ST_WAIT : ST_POWER;
          end else if (in_q.request_result == RR_UNSUP) begin
            rsp_d.setup_status = SU_FAILED;
          end
        end
        ST_POWER: begin
          rsp_d.action      = ACT_PORT_POWER;
          rsp_d.port_number = active_port_q;
          if (in_q.request_result == RR_OK) begin
            if (active_port_q >= port_count_q) begin
              setup_d = ST_WAIT;
            end else begin
              active_port_d = active_port_q + 3'd1;
            end
          end else if (in_q.request_result == RR_FAIL ||
                       in_q.request_result == RR_UNSUP) begin
            rsp_d.setup_status = SU_FAILED;
          end
        end
        ST_WAIT: begin
          rsp_d.action   = ACT_POWER_WAIT;
          rsp_d.delay_ms = {power_good_q, 1'b0};
          setup_d        = ST_DONE;
        end
        ST_DONE: begin
          rsp_d.action       = ACT_SETUP_DONE;
          rsp_d.setup_status = SU_OK;
        end
      endcase
    end else if (setup_q == ST_DONE && in_q.cmd == CMD_SERVICE) begin
      unique case (service_q)
        SV_IDLE: begin
          active_port_d = 3'd0;
          service_d     = SV_SYNC;
        end
        SV_SYNC: begin
          if (in_q.frame_count[0]) begin
            service_d = SV_GET;
          end
        end
        SV_GET: begin
          rsp_d.action = ACT_IN_POLL;
          service_d    = SV_POLL;
          poll_start_d = in_q.frame_count;
          data_seen_d  = 1'b0;
        end
        SV_POLL: begin
          if (in_q.transfer_state == TS_DONE) begin
            // Drop a second completion within the same poll.
            if (!data_seen_q) begin
              data_seen_d = 1'b1;
              pending_d   = in_q.change_bitmap;
              service_d   = (in_q.change_bitmap != 8'd0) ? SV_LOOP : SV_GET;
            end
          end else if (in_q.transfer_state == TS_STALLED) begin
            rsp_d.action = ACT_CLR_HALT;
            if (in_q.request_result == RR_OK) begin
              service_d = SV_GET;
            end
          end
        end
        SV_LOOP: begin
          if (lowest != 3'd0) begin
            pending_d     = pending_q & ~(8'd1 << lowest);
            active_port_d = lowest;
            service_d     = SV_STATUS;
          end else begin
            service_d = SV_IDLE;
          end
        end
        SV_STATUS: begin
          rsp_d.action      = ACT_GET_STATUS;
          rsp_d.port_number = active_port_q;
          // Failed read or unpowered port: repeat the status read.
          if (in_q.request_result == RR_OK && in_q.port_status_word[PS_POWER]) begin
            held_ls_d = in_q.port_status_word[PS_LOW_SPEED];
            if (in_q.port_change_word[PC_OVER_CURRENT]) begin
              service_d = SV_COC;
            end else if (in_q.port_change_word[PC_SUSPEND]) begin
              service_d = SV_CSUSP;
            end else if (in_q.port_change_word[PC_CONNECTION]) begin
              service_d = SV_CCONN;
            end else if (in_q.port_status_word[PS_CONNECT]) begin
              if (in_q.port_status_word[PS_RESET]) begin
                service_d = SV_STATUS;
              end else if (in_q.port_change_word[PC_RESET]) begin
                service_d = SV_CRESET;
              end else if (in_q.port_status_word[PS_ENABLE]) begin
                service_d = SV_ATTACH;
              end else begin
                service_d = SV_RESET;
              end
            end else begin
              service_d = SV_DETACH;
            end
          end
        end
        SV_COC, SV_CSUSP, SV_CCONN, SV_CRESET: begin
          case (service_q)
            SV_CSUSP: rsp_d.action = ACT_CLR_SUSP;
            SV_COC:   rsp_d.action = ACT_CLR_OC;
            SV_CCONN: rsp_d.action = ACT_CLR_CONN;
            default:  rsp_d.action = ACT_CLR_RESET;
          endcase
          rsp_d.port_number = active_port_q;
          if (in_q.request_result == RR_OK) begin
            service_d = SV_STATUS;
          end
        end
        SV_RESET: begin
          rsp_d.action      = ACT_PORT_RESET;
          rsp_d.port_number = active_port_q;
          if (in_q.request_result == RR_OK) begin
            rsp_d.delay_ms = RESET_DELAY_MS;
            service_d      = SV_STATUS;
          end
        end
        SV_ATTACH: begin
          rsp_d.action      = ACT_ATTACH;
          rsp_d.port_number = active_port_q;
          rsp_d.low_speed   = held_ls_q;
          service_d         = SV_SETTLE;
        end
        SV_DETACH: begin
          rsp_d.action      = ACT_DETACH;
          rsp_d.port_number = active_port_q;
          service_d         = SV_SETTLE;
        end
        default: begin
          rsp_d.action   = ACT_SETTLE;
          rsp_d.delay_ms = SETTLE_DELAY_MS;
          service_d      = SV_LOOP;
        end
      endcase
    end else if (setup_q == ST_DONE && in_q.cmd == CMD_TICK &&
                 service_q == SV_POLL) begin
      // Restart the poll once the interval has elapsed.
      if (elapsed >= {24'd0, poll_interval_q}) begin
        service_d = SV_GET;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q         <= ST_DESC;
      service_q       <= SV_IDLE;
      active_port_q   <= 3'd0;
      pending_q       <= 8'd0;
      poll_start_q    <= 32'd0;
      data_seen_q     <= 1'b0;
      port_count_q    <= 3'd0;
      power_good_q    <= 8'd0;
      held_ls_q       <= 1'b0;
      poll_interval_q <= POLL_INTERVAL_RST;
      in_valid_q      <= 1'b0;
      in_q            <= '0;
      out_valid_q     <= 1'b0;
      out_q           <= '0;
    end else begin
      if (cfg_we_i) begin
        poll_interval_q <= cfg_wdata_i;
      end
      if (in_load) begin
        in_q <= in_req_i;
      end
      in_valid_q <= in_load | (in_valid_q & ~advance);
      if (advance) begin
        setup_q       <= setup_d;
        service_q     <= service_d;
        active_port_q <= active_port_d;
        pending_q     <= pending_d;
        poll_start_q  <= poll_start_d;
        data_seen_q   <= data_seen_d;
        port_count_q  <= port_count_d;
        power_good_q  <= power_good_d;
        held_ls_q     <= held_ls_d;
        out_q         <= rsp_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `USBHPS_ASSERT(a_ls_only_attach,
    out_valid_q && out_q.low_speed |-> out_q.action == ACT_ATTACH)
  `USBHPS_ASSERT(a_delay_actions,
    out_valid_q && out_q.delay_ms != 9'd0 |->
      out_q.action == ACT_POWER_WAIT || out_q.action == ACT_PORT_RESET ||
      out_q.action == ACT_SETTLE)
  `USBHPS_ASSERT(a_status_setup_only,
    out_valid_q && out_q.setup_status != SU_BUSY |->
      out_q.action == ACT_GET_DESC || out_q.action == ACT_PORT_POWER ||
      out_q.action == ACT_SETUP_DONE)
  `USBHPS_ASSERT_ALWAYS(a_service_waits_setup,
    setup_q != ST_DONE |-> service_q == SV_IDLE)
  `USBHPS_ASSERT(a_stall_needs_full,
    in_stall_o |-> out_valid_q && in_valid_q)
  `USBHPS_ASSERT(a_port_in_range, active_port_q <= PortLimitW)

endmodule

### tb/sv/usb_hub_port_service_fsm_tb.sv
// Self-checking testbench for the USB hub port service sequencer.
// Needs usbhps_pkg and usb_hub_port_service_fsm; drives requests from a queue and
// checks every response against a cycle-free model of the setup and service sequence.
module usb_hub_port_service_fsm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import usbhps_pkg::*;

  localparam int unsigned HUB_PORTS      = 7;
  localparam int unsigned PHASE_REQUESTS = 270;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 10;

  typedef enum logic [1:0] {BOOT_DESC, BOOT_POWER, BOOT_WAIT, BOOT_DONE} boot_e;
  typedef enum logic [3:0] {
    SVC_IDLE, SVC_SYNC, SVC_GET, SVC_POLL, SVC_SCAN, SVC_STATUS, SVC_CLR_OC,
    SVC_CLR_SUSP, SVC_CLR_CONN, SVC_CLR_RST, SVC_RESET, SVC_ATTACH, SVC_DETACH,
    SVC_SETTLE
  } svc_e;
  typedef enum logic [1:0] {STALL_NEVER, STALL_TOGGLE, STALL_RANDOM, STALL_RUNS} stall_e;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req_data  = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_t       rsp_data;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;

  usb_hub_port_service_fsm #(
    .MAX_PORTS(HUB_PORTS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_req_i   (req_data),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .out_rsp_o  (rsp_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model state of the sequencer
  boot_e       boot_phase = BOOT_DESC;
  svc_e        svc_phase  = SVC_IDLE;
  logic [2:0]  cur_port   = '0;
  logic [7:0]  pending    = '0;
  logic [31:0] poll_frame = '0;
  logic        data_seen  = 1'b0;
  logic [2:0]  nports     = '0;
  logic [7:0]  pgood      = '0;
  logic        held_ls    = 1'b0;
  logic [7:0]  poll_ivl   = POLL_INTERVAL_RST;

  req_t        pending_reqs[$];
  rsp_t        expected_actions[$];
  logic [31:0] frame_now = '0;
  bit          req_taken = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned reqs_sent = 0;
  int unsigned rsps_seen = 0;
  int unsigned action_hits[16];

  function automatic rsp_t hub_next_action(req_t r);
    rsp_t        o;
    int unsigned p;
    int unsigned first;
    o = '0;
    if (r.cmd == CMD_SETUP) begin
      case (boot_phase)
        BOOT_DESC: begin
          o.action = ACT_GET_DESC;
          if (r.request_result == RR_OK) begin
            nports   = (r.desc_port_count > HUB_PORTS) ? 3'(HUB_PORTS) : r.desc_port_count;
            pgood    = r.desc_power_good;
            cur_port = 3'd1;
            if (nports == 0) boot_phase = BOOT_WAIT;
            else boot_phase = BOOT_POWER;
          end else if (r.request_result == RR_UNSUP) begin
            o.setup_status = SU_FAILED;
          end
        end
        BOOT_POWER: begin
          o.action      = ACT_PORT_POWER;
          o.port_number = cur_port;
          if (r.request_result == RR_OK) begin
            if (cur_port >= nports) boot_phase = BOOT_WAIT;
            else cur_port = cur_port + 3'd1;
          end else if (r.request_result == RR_FAIL || r.request_result == RR_UNSUP) begin
            o.setup_status = SU_FAILED;
          end
        end
        BOOT_WAIT: begin
          o.action   = ACT_POWER_WAIT;
          o.delay_ms = {pgood, 1'b0};
          boot_phase = BOOT_DONE;
        end
        default: begin
          o.action       = ACT_SETUP_DONE;
          o.setup_status = SU_OK;
        end
      endcase
    end else if (boot_phase == BOOT_DONE) begin
      if (r.cmd == CMD_SERVICE) begin
        case (svc_phase)
          SVC_IDLE: begin
            cur_port  = '0;
            svc_phase = SVC_SYNC;
          end
          SVC_SYNC: if (r.frame_count[0]) svc_phase = SVC_GET;
          SVC_GET: begin
            o.action   = ACT_IN_POLL;
            svc_phase  = SVC_POLL;
            poll_frame = r.frame_count;
            data_seen  = 1'b0;
          end
          SVC_POLL: begin
            if (r.transfer_state == TS_DONE) begin
              // a second done in the same poll carries stale data
              if (!data_seen) begin
                data_seen = 1'b1;
                pending   = r.change_bitmap;
                if (r.change_bitmap != 0) svc_phase = SVC_SCAN;
                else svc_phase = SVC_GET;
              end
            end else if (r.transfer_state == TS_STALLED) begin
              o.action = ACT_CLR_HALT;
              if (r.request_result == RR_OK) svc_phase = SVC_GET;
            end
          end
          SVC_SCAN: begin
            first = 0;
            for (p = 1; p <= 7 && p <= HUB_PORTS; p++) begin
              if (first == 0 && pending[p]) first = p;
            end
            if (first != 0) begin
              pending[first] = 1'b0;
              cur_port  = 3'(first);
              svc_phase = SVC_STATUS;
            end else begin
              svc_phase = SVC_IDLE;
            end
          end
          SVC_STATUS: begin
            o.action      = ACT_GET_STATUS;
            o.port_number = cur_port;
            if (r.request_result == RR_OK && r.port_status_word[PS_POWER]) begin
              held_ls = r.port_status_word[PS_LOW_SPEED];
              if (r.port_change_word[PC_OVER_CURRENT]) svc_phase = SVC_CLR_OC;
              else if (r.port_change_word[PC_SUSPEND]) svc_phase = SVC_CLR_SUSP;
              else if (r.port_change_word[PC_CONNECTION]) svc_phase = SVC_CLR_CONN;
              else if (r.port_status_word[PS_CONNECT]) begin
                if (r.port_status_word[PS_RESET]) svc_phase = SVC_STATUS;
                else if (r.port_change_word[PC_RESET]) svc_phase = SVC_CLR_RST;
                else if (r.port_status_word[PS_ENABLE]) svc_phase = SVC_ATTACH;
                else svc_phase = SVC_RESET;
              end else begin
                svc_phase = SVC_DETACH;
              end
            end
          end
          SVC_CLR_SUSP, SVC_CLR_OC, SVC_CLR_CONN, SVC_CLR_RST: begin
            if (svc_phase == SVC_CLR_SUSP) o.action = ACT_CLR_SUSP;
            else if (svc_phase == SVC_CLR_OC) o.action = ACT_CLR_OC;
            else if (svc_phase == SVC_CLR_CONN) o.action = ACT_CLR_CONN;
            else o.action = ACT_CLR_RESET;
            o.port_number = cur_port;
            if (r.request_result == RR_OK) svc_phase = SVC_STATUS;
          end
          SVC_RESET: begin
            o.action      = ACT_PORT_RESET;
            o.port_number = cur_port;
            if (r.request_result == RR_OK) begin
              o.delay_ms = RESET_DELAY_MS;
              svc_phase  = SVC_STATUS;
            end
          end
          SVC_ATTACH: begin
            o.action      = ACT_ATTACH;
            o.port_number = cur_port;
            o.low_speed   = held_ls;
            svc_phase     = SVC_SETTLE;
          end
          SVC_DETACH: begin
            o.action      = ACT_DETACH;
            o.port_number = cur_port;
            svc_phase     = SVC_SETTLE;
          end
          default: begin
            o.action   = ACT_SETTLE;
            o.delay_ms = SETTLE_DELAY_MS;
            svc_phase  = SVC_SCAN;
          end
        endcase
      end else if (r.cmd == CMD_TICK && svc_phase == SVC_POLL &&
                   (r.frame_count - poll_frame) >= {24'd0, poll_ivl}) begin
        svc_phase = SVC_GET;
      end
    end
    return o;
  endfunction

  function automatic req_t make_req(logic [1:0] cmd, logic [31:0] fc, logic [1:0] rr,
                                    logic [1:0] ts, logic [15:0] ps, logic [15:0] pc);
    req_t r;
    r                  = '0;
    r.cmd              = cmd;
    r.frame_count      = fc;
    r.request_result   = rr;
    r.transfer_state   = ts;
    r.port_status_word = ps;
    r.port_change_word = pc;
    return r;
  endfunction

  // Mostly service steps that walk the port loop, with ticks, setup repeats and noise.
  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    r    = '0;
    pick = $urandom_range(0, 99);
    if (pick < 4) r.cmd = CMD_SETUP;
    else if (pick < 7) r.cmd = CMD_RSVD;
    else if (pick < 22) r.cmd = CMD_TICK;
    else r.cmd = CMD_SERVICE;

    if ($urandom_range(0, 19) == 0) frame_now = $urandom();
    else if (r.cmd == CMD_TICK) frame_now = frame_now + $urandom_range(0, 40);
    else frame_now = frame_now + $urandom_range(0, 2);
    r.frame_count = frame_now;

    pick = $urandom_range(0, 99);
    if (pick < 72) r.request_result = RR_OK;
    else if (pick < 82) r.request_result = RR_BUSY;
    else if (pick < 92) r.request_result = RR_FAIL;
    else r.request_result = RR_UNSUP;

    pick = $urandom_range(0, 99);
    if (pick < 50) r.transfer_state = TS_DONE;
    else if (pick < 80) r.transfer_state = TS_PENDING;
    else if (pick < 95) r.transfer_state = TS_STALLED;
    else r.transfer_state = TS_RSVD;

    pick = $urandom_range(0, 99);
    if (pick < 20) r.change_bitmap = '0;
    else if (pick < 40) r.change_bitmap = 8'h01 << $urandom_range(0, 7);
    else r.change_bitmap = 8'($urandom());

    r.port_status_word = 16'($urandom());
    if ($urandom_range(0, 4) != 0) begin
      r.port_status_word[PS_CONNECT]   = ($urandom_range(0, 9) < 6);
      r.port_status_word[PS_ENABLE]    = ($urandom_range(0, 1) == 0);
      r.port_status_word[PS_RESET]     = ($urandom_range(0, 9) == 0);
      r.port_status_word[PS_POWER]     = ($urandom_range(0, 9) != 0);
    end
    r.port_change_word = 16'($urandom());
    if ($urandom_range(0, 4) != 0) begin
      r.port_change_word[PC_CONNECTION]   = ($urandom_range(0, 6) == 0);
      r.port_change_word[PC_SUSPEND]      = ($urandom_range(0, 6) == 0);
      r.port_change_word[PC_OVER_CURRENT] = ($urandom_range(0, 6) == 0);
      r.port_change_word[PC_RESET]        = ($urandom_range(0, 6) == 0);
    end
    r.desc_port_count = 3'($urandom());
    r.desc_power_good = 8'($urandom());
    return r;
  endfunction

  // Request side: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin : drive_requests
    logic next_valid;
    req_t next_req;
    if (rst_n) begin
      next_valid = req_valid && !req_taken;
      next_req   = req_data;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          next_req   = pending_reqs.pop_front();
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(1, 3);
              default: gap_left = $urandom_range(4, 15);
            endcase
          end
        end
      end
      req_valid <= next_valid;
      req_data  <= next_req;
    end
  end

  // Response side: stall pattern switches between modes, each held for a random span.
  stall_e      stall_mode = STALL_NEVER;
  int unsigned mode_left  = 0;
  int unsigned run_left   = 0;
  logic        run_level  = 1'b0;

  always @(negedge clk) begin : drive_stall
    logic next_stall;
    if (mode_left == 0) begin
      stall_mode = stall_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(30, 200);
    end
    mode_left--;
    case (stall_mode)
      STALL_NEVER:  next_stall = 1'b0;
      STALL_TOGGLE: next_stall = !rsp_stall;
      STALL_RANDOM: next_stall = ($urandom_range(0, 9) < 3);
      default: begin
        if (run_left == 0) begin
          run_level = !run_level;
          run_left  = $urandom_range(1, 12);
        end
        run_left--;
        next_stall = run_level;
      end
    endcase
    rsp_stall <= next_stall;
  end

  always @(posedge clk) begin : monitor
    rsp_t want;
    bit   rsp_hit;
    if (rst_n) begin
      req_taken = req_valid && !req_stall;
      rsp_hit   = rsp_valid && !rsp_stall;
      if (req_taken) begin
        expected_actions.push_back(hub_next_action(req_data));
        reqs_sent++;
      end
      if (rsp_hit) begin
        rsps_seen++;
        action_hits[rsp_data.action]++;
        if (expected_actions.size() == 0) begin
          $error("unexpected response: action %0d port %0d", rsp_data.action,
                 rsp_data.port_number);
          mismatches++;
        end else begin
          want = expected_actions.pop_front();
          if (rsp_data.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, rsp_data.action);
            mismatches++;
          end
          if (rsp_data.port_number !== want.port_number) begin
            $error("port_number: expected %0d, got %0d", want.port_number,
                   rsp_data.port_number);
            mismatches++;
          end
          if (rsp_data.low_speed !== want.low_speed) begin
            $error("low_speed: expected %0d, got %0d", want.low_speed, rsp_data.low_speed);
            mismatches++;
          end
          if (rsp_data.delay_ms !== want.delay_ms) begin
            $error("delay_ms: expected %0d, got %0d", want.delay_ms, rsp_data.delay_ms);
            mismatches++;
          end
          if (rsp_data.setup_status !== want.setup_status) begin
            $error("setup_status: expected %0d, got %0d", want.setup_status,
                   rsp_data.setup_status);
            mismatches++;
          end
        end
      end
      if (req_taken || rsp_hit) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || req_valid || expected_actions.size() > 0);
  endtask

  task automatic write_poll_interval(logic [7:0] value);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    poll_ivl   = value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0]  ivl_plan[6];
    int unsigned i;
    int unsigned ph;
    ivl_plan = '{POLL_INTERVAL_RST, 8'd255, 8'd1, 8'd0, 8'd0, POLL_INTERVAL_RST};
    ivl_plan[4] = 8'($urandom_range(2, 254));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // service and ticks before setup completes are dropped
    pending_reqs.push_back(make_req(CMD_SERVICE, 32'd1, RR_OK, TS_DONE, '0, '0));
    pending_reqs.push_back(make_req(CMD_TICK, 32'hFFFF_FFFF, RR_OK, TS_DONE, '0, '0));
    pending_reqs.push_back(make_req(CMD_RSVD, 32'd3, RR_OK, TS_DONE, '0, '0));
    // descriptor fetch: fail keeps busy, unsupported reports failure; then port power, power wait, setup done
    pending_reqs.push_back(make_req(CMD_SETUP, '0, RR_FAIL, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SETUP, '0, RR_BUSY, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SETUP, '0, RR_UNSUP, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SETUP, '0, RR_OK, TS_PENDING, '0, '0));
    pending_reqs[$].desc_port_count = 3'd7;
    pending_reqs[$].desc_power_good = 8'hFF;
    pending_reqs.push_back(make_req(CMD_SETUP, '0, RR_FAIL, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SETUP, '0, RR_UNSUP, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SETUP, '0, RR_BUSY, TS_PENDING, '0, '0));
    for (i = 0; i < HUB_PORTS; i++)
      pending_reqs.push_back(make_req(CMD_SETUP, '0, RR_OK, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SETUP, '0, RR_OK, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SETUP, '0, RR_OK, TS_PENDING, '0, '0));
    // first poll: wait for odd frame, stall recovery, full change bitmap
    pending_reqs.push_back(make_req(CMD_SERVICE, 32'd0, RR_OK, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SERVICE, 32'd0, RR_OK, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SERVICE, 32'hFFFF_FFFF, RR_OK, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SERVICE, 32'hFFFF_FFF0, RR_OK, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SERVICE, 32'hFFFF_FFF0, RR_BUSY, TS_STALLED,
                                    16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(make_req(CMD_SERVICE, 32'hFFFF_FFF1, RR_OK, TS_STALLED, '0, '0));
    pending_reqs.push_back(make_req(CMD_SERVICE, 32'hFFFF_FFF2, RR_OK, TS_PENDING, '0, '0));
    pending_reqs.push_back(make_req(CMD_SERVICE, 32'hFFFF_FFF2, RR_OK, TS_DONE, '0, '0));
    pending_reqs[$].change_bitmap = 8'hFF;
    pending_reqs.push_back(make_req(CMD_SERVICE, 32'hFFFF_FFF3, RR_OK, TS_DONE, '0, '0));
    frame_now = 32'hFFFF_FFF4;

    for (ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_poll_interval(ivl_plan[ph]);
      for (i = 0; i < PHASE_REQUESTS; i++) pending_reqs.push_back(random_req());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d requests, %0d responses over six poll interval settings",
             reqs_sent, rsps_seen);
    $display("run: %0d attach, %0d detach, %0d port reset, %0d clear halt, %0d settle",
             action_hits[ACT_ATTACH], action_hits[ACT_DETACH], action_hits[ACT_PORT_RESET],
             action_hits[ACT_CLR_HALT], action_hits[ACT_SETTLE]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### usb_hub_port_service_fsm.f
+incdir+hw/rtl
hw/rtl/usbhps_pkg.sv
hw/rtl/usb_hub_port_service_fsm.sv
tb/sv/usb_hub_port_service_fsm_tb.sv
